FILE: rtl/sdmc_pkg.sv
// ----------------------------------------------------------------------------
// sdmc_pkg
// Shared codes and line geometry for the split direct-mapped cache.
// ----------------------------------------------------------------------------
package sdmc_pkg;

   localparam int WORD_W      = 32;
   localparam int WORDS       = 4;
   localparam int LINE_W      = WORD_W * WORDS;
   localparam int WSEL_W      = 2;

   // request modes
   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_REFILL = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_READ_DATA = 2'd0;
   localparam logic [1:0] KIND_MEM_WRITE = 2'd1;
   localparam logic [1:0] KIND_MEM_READ  = 2'd2;
   localparam logic [1:0] KIND_WRITE_ACK = 2'd3;

   typedef logic [LINE_W-1:0] line_type;

   // replace one word of a line
   function automatic line_type merge_word(line_type line, logic [WSEL_W-1:0] sel,
                                           logic [WORD_W-1:0] word);
      line_type res;
      res = line;
      res[sel*WORD_W +: WORD_W] = word;
      return res;
   endfunction

endpackage

FILE: rtl/split_direct_mapped_write_back_cache_top.sv
// ----------------------------------------------------------------------------
// split_direct_mapped_write_back_cache_top
// Data and instruction direct-mapped write-back caches sharing one tag RAM
// and one line RAM.
// ----------------------------------------------------------------------------
// A request is taken only in the idle state, one at a time. On a hit, the
// accept cycle issues the tag/line RAM read, the next cycle checks the tag and
// registers the response, and the block is idle again in the cycle the
// response is valid. A held response output stalls the lookup until it frees
// up. A miss spends its lookup cycle, then issues its optional four victim
// writes and four refill read requests, one per cycle as the response side
// takes them, then waits for four refill requests; after the fourth one the
// fill state installs the line and answers once the response output is free.
// The lookup waits on the registered read of the tag and line RAMs. After
// reset the block runs a clearing pass over all 2 * LINE_COUNT tag RAM
// entries, during which req_ready stays low. CPU requests that arrive while a
// miss is pending, and refill requests with no miss pending, are dropped
// without a response.
// ----------------------------------------------------------------------------
module split_direct_mapped_write_back_cache_top #(
   parameter int LINE_COUNT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic        req_cache_select,
   input  logic [31:0] req_address,
   input  logic [31:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_data_out,
   output logic        rsp_last
);
   import sdmc_pkg::*;

   localparam int IDX_W   = $clog2(LINE_COUNT);
   localparam int ENTRY_W = IDX_W + 1;
   localparam int TAG_W   = 32 - 4 - IDX_W;
   localparam int META_W  = TAG_W + 2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_WB, ST_RQ, ST_FILL
   } state_type;

   state_type          state_ff, state_in;
   logic [ENTRY_W-1:0] clr_ff, clr_in;
   logic               pend_ff, pend_in;
   logic               pwrite_ff, pwrite_in;
   logic               psel_ff, psel_in;
   logic [31:0]        paddr_ff, paddr_in;
   logic [31:0]        pdata_ff, pdata_in;
   logic [WORD_W-1:0]  rbuf_ff [WORDS];
   logic [WORD_W-1:0]  rbuf_in [WORDS];
   logic [1:0]         rcnt_ff, rcnt_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               meta_we, data_we, rd_en;
   logic [ENTRY_W-1:0] wr_entry, rd_entry, pentry;
   logic [META_W-1:0]  meta_wdata, meta_rdata;
   line_type           data_wdata, data_rdata, fill_line;
   logic [TAG_W-1:0]   ptag, vtag;
   logic               vvalid, vdirty, hit, out_free;

   // tag RAM: {valid, dirty, tag}
   sdmc_ram #(.WIDTH(META_W), .DEPTH(2 * LINE_COUNT)) u_meta (
      .clock  (clock),
      .wr_en  (meta_we),
      .wr_addr(wr_entry),
      .wr_data(meta_wdata),
      .rd_en  (rd_en),
      .rd_addr(rd_entry),
      .rd_data(meta_rdata)
   );

   // line RAM
   sdmc_ram #(.WIDTH(LINE_W), .DEPTH(2 * LINE_COUNT)) u_data (
      .clock  (clock),
      .wr_en  (data_we),
      .wr_addr(wr_entry),
      .wr_data(data_wdata),
      .rd_en  (rd_en),
      .rd_addr(rd_entry),
      .rd_data(data_rdata)
   );

   assign rd_entry = {req_cache_select, req_address[IDX_W+3:4]};
   assign pentry   = {psel_ff, paddr_ff[IDX_W+3:4]};
   assign ptag     = paddr_ff[31:IDX_W+4];
   assign vvalid   = meta_rdata[META_W-1];
   assign vdirty   = meta_rdata[META_W-2];
   assign vtag     = meta_rdata[TAG_W-1:0];
   assign hit      = vvalid && (vtag == ptag);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fill_line = {rbuf_ff[3], rbuf_ff[2], rbuf_ff[1], rbuf_ff[0]};

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_mem_address = rsp_addr_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      pwrite_in    = pwrite_ff;
      psel_in      = psel_ff;
      paddr_in     = paddr_ff;
      pdata_in     = pdata_ff;
      rbuf_in      = rbuf_ff;
      rcnt_in      = rcnt_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      meta_we      = 1'b0;
      data_we      = 1'b0;
      rd_en        = 1'b0;
      wr_entry     = pentry;
      meta_wdata   = {1'b1, 1'b1, ptag};
      data_wdata   = merge_word(data_rdata, paddr_ff[3:2], pdata_ff);

      unique case (state_ff)
         // sweep the tag RAM to invalid
         ST_CLEAR: begin
            meta_we    = 1'b1;
            wr_entry   = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         // take one request
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_mode == MODE_READ || req_mode == MODE_WRITE) && !pend_ff) begin
                  pwrite_in = (req_mode == MODE_WRITE);
                  psel_in   = req_cache_select;
                  paddr_in  = req_address;
                  pdata_in  = req_word_data;
                  rd_en     = 1'b1;
                  state_in  = ST_LOOKUP;
               end else if (req_mode == MODE_REFILL && pend_ff) begin
                  rbuf_in[rcnt_ff] = req_word_data;
                  rcnt_in          = rcnt_ff + 1'b1;
                  if (rcnt_ff == 2'd3) begin
                     state_in = ST_FILL;
                  end
               end
            end
         end
         // check the tag, answer a hit or start a miss
         ST_LOOKUP: begin
            if (hit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_addr_in  = '0;
                  if (pwrite_ff) begin
                     meta_we     = 1'b1;
                     data_we     = 1'b1;
                     rsp_kind_in = KIND_WRITE_ACK;
                     rsp_data_in = '0;
                  end else begin
                     rsp_kind_in = KIND_READ_DATA;
                     rsp_data_in = data_rdata[paddr_ff[3:2]*WORD_W +: WORD_W];
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               pend_in  = 1'b1;
               rcnt_in  = '0;
               cnt_in   = '0;
               state_in = (vvalid && vdirty) ? ST_WB : ST_RQ;
            end
         end
         // write out the dirty victim
         ST_WB: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_MEM_WRITE;
               rsp_addr_in  = {vtag, paddr_ff[IDX_W+3:4], cnt_ff, 2'b00};
               rsp_data_in  = data_rdata[cnt_ff*WORD_W +: WORD_W];
               rsp_last_in  = 1'b0;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == 2'd3) begin
                  state_in = ST_RQ;
               end
            end
         end
         // request the missing line
         ST_RQ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_MEM_READ;
               rsp_addr_in  = {paddr_ff[31:4], cnt_ff, 2'b00};
               rsp_data_in  = '0;
               rsp_last_in  = (cnt_ff == 2'd3);
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         // install the refilled line and finish the access
         ST_FILL: begin
            if (out_free) begin
               meta_we      = 1'b1;
               data_we      = 1'b1;
               meta_wdata   = {1'b1, pwrite_ff, ptag};
               data_wdata   = pwrite_ff ? merge_word(fill_line, paddr_ff[3:2], pdata_ff)
                                        : fill_line;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_addr_in  = '0;
               if (pwrite_ff) begin
                  rsp_kind_in = KIND_WRITE_ACK;
                  rsp_data_in = '0;
               end else begin
                  rsp_kind_in = KIND_READ_DATA;
                  rsp_data_in = rbuf_ff[paddr_ff[3:2]];
               end
               pend_in  = 1'b0;
               rcnt_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rcnt_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rcnt_ff      <= rcnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pwrite_ff   <= pwrite_in;
      psel_ff     <= psel_in;
      paddr_ff    <= paddr_in;
      pdata_ff    <= pdata_in;
      rbuf_ff     <= rbuf_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: rtl/sdmc_ram.sv
// ----------------------------------------------------------------------------
// sdmc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sdmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split direct-mapped write-back cache. A local
// cache model predicts every response at the moment a request is taken, and
// each response is checked in order, field by field, against that model.
// ----------------------------------------------------------------------------
module tb_top;
   import sdmc_pkg::*;

   localparam logic [1:0] MODE_NOP = 2'd3;   // unused mode, dropped by the block
   localparam int ENTRIES = 4096;            // two caches of 2048 lines

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] data;
      logic        last;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_READ;
   logic        req_cache_select = 1'b0;
   logic [31:0] req_address = '0;
   logic [31:0] req_word_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_mem_address;
   logic [31:0] rsp_data_out;
   logic        rsp_last;

   // cache model state
   logic [16:0]     mdl_tag   [ENTRIES];
   logic            mdl_valid [ENTRIES];
   logic            mdl_dirty [ENTRIES];
   logic [LINE_W-1:0] mdl_line [ENTRIES];
   logic            miss_open;
   logic [1:0]      miss_mode;
   logic            miss_sel;
   logic [31:0]     miss_addr;
   logic [31:0]     miss_data;
   logic [LINE_W-1:0] fill_line;
   int              fill_cnt;

   rsp_type expected_rsps[$];
   int   errors = 0;
   bit   quiet = 0;          // no idling on either side while set
   int   hold_off_req = 0;   // bumped to ask for a long response stall
   int   hold_off_seen = 0;
   int   hold_cnt = 0;

   split_direct_mapped_write_back_cache_top u_dut (.*);

   always #5 clock = ~clock;

   // Response side: random stalls, plus long hold-off on request
   always @(posedge clock) begin
      if (hold_off_req != hold_off_seen) begin
         hold_off_seen <= hold_off_req;
         hold_cnt <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 10);
      end
   end

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response kind %0d addr %h data %h last %0d",
                     $time, rsp_kind, rsp_mem_address, rsp_data_out, rsp_last);
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_kind !== exp_r.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, rsp_kind);
               errors++;
            end
            if (rsp_mem_address !== exp_r.addr) begin
               $display("%0t: mem_address expected %h actual %h",
                        $time, exp_r.addr, rsp_mem_address);
               errors++;
            end
            if (rsp_data_out !== exp_r.data) begin
               $display("%0t: data_out expected %h actual %h", $time, exp_r.data, rsp_data_out);
               errors++;
            end
            if (rsp_last !== exp_r.last) begin
               $display("%0t: last expected %0d actual %0d", $time, exp_r.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic void push_rsp(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic l);
      rsp_type r;
      r.kind = k;
      r.addr = a;
      r.data = d;
      r.last = l;
      expected_rsps.push_back(r);
   endfunction

   // Finish a cpu access on a present line
   function automatic void complete_access(logic [1:0] mode, logic [11:0] e,
                                           logic [31:0] addr, logic [31:0] data);
      logic [1:0] w;
      w = addr[3:2];
      if (mode == MODE_WRITE) begin
         mdl_line[e][w*32 +: 32] = data;
         mdl_dirty[e] = 1'b1;
         push_rsp(KIND_WRITE_ACK, '0, '0, 1'b1);
      end else begin
         push_rsp(KIND_READ_DATA, '0, mdl_line[e][w*32 +: 32], 1'b1);
      end
   endfunction

   // Predict the responses to one accepted request
   function automatic void predict_cache(logic [1:0] mode, logic sel,
                                         logic [31:0] addr, logic [31:0] data);
      logic [11:0] e;
      logic [31:0] vbase;
      if (mode == MODE_REFILL) begin
         if (!miss_open) return;
         fill_line[fill_cnt*32 +: 32] = data;
         fill_cnt++;
         if (fill_cnt < 4) return;
         e = {miss_sel, miss_addr[14:4]};
         mdl_line[e]  = fill_line;
         mdl_tag[e]   = miss_addr[31:15];
         mdl_valid[e] = 1'b1;
         mdl_dirty[e] = 1'b0;
         miss_open = 1'b0;
         fill_cnt = 0;
         complete_access(miss_mode, e, miss_addr, miss_data);
         return;
      end
      if (mode == MODE_NOP || miss_open) return;
      e = {sel, addr[14:4]};
      if (mdl_valid[e] && mdl_tag[e] == addr[31:15]) begin
         complete_access(mode, e, addr, data);
         return;
      end
      // write back a dirty victim, then request the line
      if (mdl_valid[e] && mdl_dirty[e]) begin
         vbase = {mdl_tag[e], e[10:0], 4'b0000};
         for (int i = 0; i < 4; i++)
            push_rsp(KIND_MEM_WRITE, vbase + 4*i, mdl_line[e][i*32 +: 32], 1'b0);
         mdl_dirty[e] = 1'b0;
      end
      for (int i = 0; i < 4; i++)
         push_rsp(KIND_MEM_READ, {addr[31:4], 4'b0000} + 4*i, '0, i == 3);
      miss_open = 1'b1;
      miss_mode = mode;
      miss_sel  = sel;
      miss_addr = addr;
      miss_data = data;
      fill_cnt  = 0;
   endfunction

   // Offer one request and wait for it to be taken; called at a rising edge
   task automatic send_req(logic [1:0] mode, logic sel, logic [31:0] addr,
                           logic [31:0] data);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_cache_select <= sel;
      req_address <= addr;
      req_word_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_cache(mode, sel, addr, data);
   endtask

   // A cpu access followed, on a miss, by its four refill words
   task automatic access_line(logic [1:0] mode, logic sel, logic [31:0] addr,
                              logic [31:0] data, bit noisy);
      send_req(mode, sel, addr, data);
      while (miss_open) begin
         if (noisy && $urandom_range(0, 99) < 15)
            send_req($urandom_range(0, 1) ? MODE_NOP : 2'($urandom_range(0, 1)),
                     1'($urandom), $urandom, $urandom);
         else
            send_req(MODE_REFILL, 1'($urandom), $urandom, $urandom);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Extremes, hit/miss, dirty victim and every dropped case
   task automatic test_directed();
      send_req(MODE_REFILL, 1'b0, 32'h0, 32'hFFFF_FFFF);               // refill, no miss
      send_req(MODE_NOP, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);          // unused mode
      send_req(MODE_READ, 1'b0, 32'h0000_0000, 32'h0);                 // read miss
      send_req(MODE_WRITE, 1'b1, 32'h1234_5678, 32'hDEAD_BEEF);        // dropped, miss open
      send_req(MODE_REFILL, 1'b0, 32'h0, 32'hFFFF_FFFF);
      send_req(MODE_REFILL, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      send_req(MODE_REFILL, 1'b0, 32'h0, 32'hA5A5_5A5A);
      send_req(MODE_REFILL, 1'b0, 32'h0, 32'h5A5A_A5A5);
      send_req(MODE_READ, 1'b0, 32'h0000_000F, 32'h0);                 // read hit, low bits
      send_req(MODE_WRITE, 1'b0, 32'h0000_0006, 32'hFFFF_FFFF);        // write hit, dirty
      access_line(MODE_READ, 1'b0, 32'hFFFF_8003, 32'h0, 0);           // dirty victim out
      access_line(MODE_WRITE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);  // write miss
      access_line(MODE_READ, 1'b1, 32'h0000_7FF0, 32'h0, 0);           // dirty victim out
      send_req(MODE_READ, 1'b1, 32'h0000_7FFC, 32'h0);
   endtask

   // Mostly well-formed accesses over a few tags and lines, with noise
   task automatic test_random(int n);
      logic [31:0] addr;
      for (int i = 0; i < n; i++) begin
         quiet = (i >= n/3 && i < n/3 + 40);
         if ($urandom_range(0, 99) < 85) begin
            addr[31:15] = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                      : 17'($urandom_range(0, 3));
            addr[14:4]  = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                      : 11'($urandom_range(0, 7));
            addr[3:0]   = 4'($urandom);
            access_line(2'($urandom_range(0, 1)), 1'($urandom), addr, $urandom, 1);
         end else begin
            send_req(2'($urandom_range(0, 3)), 1'($urandom), $urandom, $urandom);
         end
         if (i == n/2) wait_drained();
      end
      quiet = 0;
   endtask

   // Hold responses off while dirty misses keep coming, so the block stalls
   task automatic test_backpressure();
      hold_off_req++;
      for (int i = 0; i < 6; i++) begin
         access_line(MODE_WRITE, 1'b0, {17'(i), 11'd5, 4'd0}, $urandom, 0);
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(75);
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_dirty[i] = 1'b0;
      end
      miss_open = 1'b0;
      fill_cnt = 0;
      fill_line = '0;
      #8ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
